// ----- hw/rtl/aes_pkg.sv -----
// Shared types, constants and round functions for the AES-128 block cipher.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package aes_pkg;

    localparam int BLK_W   = 128;
    localparam int HALF_W  = 64;
    localparam int RND_N   = 10;
    localparam int RK_W    = 4;
    localparam logic ACT_ENC = 1'b0;
    localparam logic ACT_DEC = 1'b1;

    typedef struct packed {
        logic load;      // capture the input word and its action
        logic enc_rnd;   // substitution and row shift step (inverse when decrypting)
        logic dec_rnd;   // add round key step with its column mix
        logic last;      // first or final key slot (no column mix)
        logic kx_start;  // load the key schedule from the key registers
        logic kx_step;   // advance the key schedule one round
        logic [RK_W-1:0] rnd;
    } t_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    // Byte n of a 128-bit word sits in bits [127-8n -: 8].
    function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] w, input int n);
        return w[BLK_W-1-8*n -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [BLK_W-1:0] sub_shift(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[BLK_W-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c+r)%4))];
            end
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] inv_shift_sub(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[BLK_W-1-8*(r+4*((c+r)%4)) -: 8] = ISBOX[get_byte(s, r + 4*c)];
            end
        end
        return t;
    endfunction

    function automatic logic [BLK_W-1:0] mix_cols(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            t[BLK_W-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[BLK_W-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[BLK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[BLK_W-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    // Inverse mix: pre-multiply by {04}x^2+{05} then apply the forward mix.
    function automatic logic [BLK_W-1:0] inv_mix_cols(input logic [BLK_W-1:0] s);
        logic [BLK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3, u, v;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            t[BLK_W-1-8*(4*c)   -: 8] = a0 ^ u;
            t[BLK_W-1-8*(4*c+1) -: 8] = a1 ^ v;
            t[BLK_W-1-8*(4*c+2) -: 8] = a2 ^ u;
            t[BLK_W-1-8*(4*c+3) -: 8] = a3 ^ v;
        end
        return mix_cols(t);
    endfunction

    function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] k,
                                                  input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/aes_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/aes_datapath.sv -----
// Datapath: key registers, key schedule, round key store and one round unit.
// Depends on aes_pkg and aes_ram.
`default_nettype none
module aes_datapath
    import aes_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [HALF_W-1:0] i_cfg_data,
    input  wire logic              i_cfg_hit,
    input  wire t_cmd              i_cmd,
    input  wire logic [BLK_W-1:0]  i_block,
    input  wire logic              i_action,
    output logic [BLK_W-1:0]       o_state
);
    logic [BLK_W-1:0] r_key, r_sched, r_state;
    logic [7:0]       r_rc;
    logic             r_dec;
    logic [BLK_W-1:0] rk_rd;
    logic [RK_W-1:0]  rk_raddr;
    logic [BLK_W-1:0] n_state;

    // Decryption walks the round keys from the last one down.
    assign rk_raddr = r_dec ? (RK_W'(RND_N) - i_cmd.rnd) : i_cmd.rnd;

    // Round keys are stored as 128-bit rows; reads are registered and land in the cycle after the address.
    aes_ram #(.WIDTH(BLK_W), .DEPTH(RND_N + 1)) u_rk (
        .i_clk  (i_clk),
        .i_we   (i_cmd.kx_start || i_cmd.kx_step),
        .i_waddr(i_cmd.rnd),
        .i_wdata(i_cmd.kx_start ? r_key : key_next(r_sched, r_rc)),
        .i_raddr(rk_raddr),
        .o_rdata(rk_rd)
    );

    // A round runs substitution and row shift, the round key read, then the
    // add-key step. The column mix comes before the key when encrypting and
    // after it when decrypting.
    always_comb begin
        n_state = r_state;
        if (i_cmd.load) begin
            n_state = i_block;
        end else if (i_cmd.enc_rnd) begin
            n_state = (r_dec ? inv_shift_sub(r_state) : sub_shift(r_state));
        end else if (i_cmd.dec_rnd) begin
            if (r_dec) begin
                n_state = r_state ^ rk_rd;
                if (!i_cmd.last) begin
                    n_state = inv_mix_cols(n_state);
                end
            end else begin
                n_state = (i_cmd.last ? r_state : mix_cols(r_state)) ^ rk_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we && i_cfg_hit) begin
            if (i_cfg_idx) r_key[HALF_W-1:0] <= i_cfg_data;
            else           r_key[BLK_W-1:HALF_W] <= i_cfg_data;
        end
        if (i_cmd.kx_start) begin
            r_sched <= r_key;
            r_rc    <= 8'h01;
        end else if (i_cmd.kx_step) begin
            r_sched <= key_next(r_sched, r_rc);
            r_rc    <= xtime(r_rc);
        end
        if (i_cmd.load) begin
            r_dec <= i_action;
        end
        r_state <= n_state;
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

// ----- hw/rtl/aes_ctrl.sv -----
// Controller: sequences key expansion and the rounds of one word.
// Depends on aes_pkg.
`default_nettype none
module aes_ctrl
    import aes_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_key_wr,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_KEXP, S_RD, S_ARK, S_SUB, S_DONE} t_state;
    t_state r_st;
    logic [RK_W-1:0] r_rnd;
    logic r_keys_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_rnd     <= '0;
            r_keys_ok <= 1'b0;
        end else begin
            if (i_key_wr) r_keys_ok <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_st  <= (r_keys_ok && !i_key_wr) ? S_RD : S_KEXP;
                        r_rnd <= '0;
                    end
                end
                S_KEXP: begin
                    if (r_rnd == RK_W'(RND_N)) begin
                        r_keys_ok <= 1'b1;
                        r_st      <= S_RD;
                        r_rnd     <= '0;
                    end else begin
                        r_rnd <= r_rnd + 1'b1;
                    end
                end
                S_RD:  r_st <= S_ARK;
                S_ARK: r_st <= (r_rnd == RK_W'(RND_N)) ? S_DONE : S_SUB;
                S_SUB: begin
                    r_rnd <= r_rnd + 1'b1;
                    r_st  <= S_RD;
                end
                S_DONE: if (i_out_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_DONE);
    always_comb begin
        o_cmd          = '0;
        o_cmd.rnd      = r_rnd;
        o_cmd.load     = (r_st == S_IDLE) && i_in_valid;
        o_cmd.kx_start = (r_st == S_KEXP) && (r_rnd == '0);
        o_cmd.kx_step  = (r_st == S_KEXP) && (r_rnd != '0);
        o_cmd.enc_rnd  = (r_st == S_SUB);
        o_cmd.dec_rnd  = (r_st == S_ARK);
        o_cmd.last     = (r_rnd == '0) || (r_rnd == RK_W'(RND_N));
    end
endmodule
`default_nettype wire

// ----- hw/rtl/aes128_block_cipher.sv -----
// AES-128 block cipher, one word in flight.
// Sequence: once the input word is accepted, each of the 11 round keys gets a key read and
// an add-key step, plus one substitution step per round; o_valid then rises.
// The first word after reset or a key write first runs the key expansion.
// Input waits for the result: no new word is accepted until the result has been taken.
// Reset (synchronous, active low) clears control and sets both key registers to zero.
`default_nettype none
module aes128_block_cipher
    import aes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    input  wire logic        i_action,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low
);
    t_cmd cmd;
    logic [BLK_W-1:0] st;

    aes_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_wr(i_cfg_we),
        .i_in_valid(i_valid), .o_in_ready(o_ready),
        .o_out_valid(o_valid), .i_out_ready(i_ready), .o_cmd(cmd)
    );

    aes_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx[0]),
        .i_cfg_data(i_cfg_data), .i_cfg_hit(1'b1), .i_cmd(cmd),
        .i_block({i_block_high, i_block_low}), .i_action(i_action), .o_state(st)
    );

    assign o_result_high = st[BLK_W-1:HALF_W];
    assign o_result_low  = st[HALF_W-1:0];
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the AES-128 block cipher aes128_block_cipher.
// Predicts every result with its own cipher model; depends on aes_pkg and the RTL only.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import aes_pkg::*;

    localparam logic KEY_HIGH_IDX = 1'b0;
    localparam logic KEY_LOW_IDX  = 1'b1;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_block_high = '0;
    logic [63:0] i_block_low = '0;
    logic        i_action = ACT_ENC;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;

    aes128_block_cipher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_block_high(i_block_high), .i_block_low(i_block_low), .i_action(i_action),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_high(o_result_high), .o_result_low(o_result_low)
    );

    always #5 i_clk = ~i_clk;

    // Cipher predictor state.
    logic [7:0]   fwd_sub [256];
    logic [7:0]   rev_sub [256];
    logic [63:0]  key_hi_q = '0;
    logic [63:0]  key_lo_q = '0;
    logic [127:0] round_keys [11];

    t_block pending_results [$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_request = 0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // The substitution table is derived from field inverses and the affine map.
    task automatic build_sub_tables();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = '0;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
            fwd_sub[x] = s;
            rev_sub[s] = x[7:0];
        end
    endtask

    function automatic logic [7:0] byte_at(input logic [127:0] w, input int n);
        return w[127-8*n -: 8];
    endfunction

    task automatic expand_round_keys();
        logic [127:0] k;
        logic [7:0]   t [4];
        logic [7:0]   rc;
        rc = 8'h01;
        k = {key_hi_q, key_lo_q};
        round_keys[0] = k;
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 4; i++) t[i] = fwd_sub[byte_at(k, 12 + ((i + 1) % 4))];
            t[0] ^= rc;
            rc = gf_mul(rc, 8'h02);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) begin
                    k[127-8*(4*c+i) -: 8] = byte_at(k, 4*c+i) ^ t[i];
                    t[i] = byte_at(k, 4*c+i);
                end
            round_keys[r] = k;
        end
    endtask

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input bit inverse);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inverse) t[127-8*(r+4*((c+r)%4)) -: 8] = byte_at(s, r + 4*c);
                else         t[127-8*(r+4*c) -: 8] = byte_at(s, r + 4*((c+r)%4));
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inverse);
        logic [127:0] t;
        logic [7:0]   m [4];
        logic [7:0]   o;
        if (inverse) m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
        else         m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                o = '0;
                for (int k = 0; k < 4; k++) o ^= gf_mul(byte_at(s, 4*c+k), m[(k + 4 - r) % 4]);
                t[127-8*(4*c+r) -: 8] = o;
            end
        return t;
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input bit inverse);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
            t[127-8*i -: 8] = inverse ? rev_sub[byte_at(s, i)] : fwd_sub[byte_at(s, i)];
        return t;
    endfunction

    function automatic t_block cipher_block(input t_block b, input logic act);
        logic [127:0] s;
        s = {b.high, b.low};
        if (act == ACT_ENC) begin
            s ^= round_keys[0];
            for (int r = 1; r <= 10; r++) begin
                s = shift_rows(sub_bytes(s, 0), 0);
                if (r < 10) s = mix_columns(s, 0);
                s ^= round_keys[r];
            end
        end else begin
            for (int r = 10; r >= 1; r--) begin
                s ^= round_keys[r];
                if (r < 10) s = mix_columns(s, 1);
                s = sub_bytes(shift_rows(s, 1), 1);
            end
            s ^= round_keys[0];
        end
        return {s[127:64], s[63:0]};
    endfunction

    // Offers one word; returns right after the edge that accepted it.
    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo, input logic act);
        int gap;
        t_block b;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_block_high = hi;
        i_block_low  = lo;
        i_action     = act;
        i_valid      = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        b.high = hi;
        b.low  = lo;
        pending_results = {pending_results, cipher_block(b, act)};
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Key writes happen only with the block drained.
    task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = KEY_HIGH_IDX;
        i_cfg_data = hi;
        @(negedge i_clk);
        i_cfg_idx = KEY_LOW_IDX;
        i_cfg_data = lo;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        key_hi_q = hi;
        key_lo_q = lo;
        expand_round_keys();
    endtask

    task automatic test_reset_key();
        send_word('0, '0, ACT_ENC);
        send_word('1, '1, ACT_DEC);
        send_word(64'h0011223344556677, 64'h8899AABBCCDDEEFF, ACT_ENC);
    endtask

    task automatic test_standard_vector();
        write_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
        send_word(64'h0011223344556677, 64'h8899AABBCCDDEEFF, ACT_ENC);
        send_word(64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A, ACT_DEC);
    endtask

    task automatic test_key_extremes();
        write_key('1, '1);
        send_word('0, '1, ACT_ENC);
        send_word('1, '0, ACT_DEC);
        write_key('0, '1);
        send_word(64'h8000000000000000, 64'h1, ACT_ENC);
        send_word(64'h1, 64'h8000000000000000, ACT_DEC);
        write_key('1, '0);
        send_word(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, ACT_ENC);
        send_word(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, ACT_DEC);
        // Rewriting the same key must give the same expansion.
        write_key('1, '0);
        send_word('0, '0, ACT_DEC);
        send_word('1, '1, ACT_ENC);
    endtask

    function automatic logic [63:0] rand_half();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_random(input int n, input bit with_hold);
        write_key({$urandom, $urandom}, {$urandom, $urandom});
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == n / 4) hold_request = 1;
            send_word(rand_half(), rand_half(), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        build_sub_tables();
        expand_round_keys();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_key();
        test_standard_vector();
        test_key_extremes();
        send_idle_pct = 16;
        recv_idle_pct = 66;
        test_random(280, 0);
        send_idle_pct = 66;
        recv_idle_pct = 16;
        test_random(280, 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(290, 1);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request == 1) begin
                hold_request = 2;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected word %h %h", o_result_high, o_result_low);
            end else begin
                want = pending_results.pop_front();
                if (want.high !== o_result_high || want.low !== o_result_low) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch expected %h %h got %h %h",
                                 want.high, want.low, o_result_high, o_result_low);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/aes_pkg.sv
hw/rtl/aes_ram.sv
hw/rtl/aes_datapath.sv
hw/rtl/aes_ctrl.sv
hw/rtl/aes128_block_cipher.sv
sim/tb.sv
